// File: rtl/vsc_pkg.sv
// Shared constants, register codes and helpers for the shift cipher block.
`timescale 1ns / 1ps

package vsc_pkg;

  // Largest key the block supports, in characters
  localparam int KEY_MAX_DEF = 16;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Field widths
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 5;

  // Alphabet constants
  localparam logic [CHAR_W-1:0] CHAR_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h7a;
  localparam int                ALPHA_LEN = 26;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECODE_MODE = 2'd0,
    CFG_KEY_LENGTH  = 2'd1,
    CFG_KEY_LOW     = 2'd2,
    CFG_KEY_HIGH    = 2'd3
  } cfg_reg_t;

  // True for 'a' to 'z'
  function automatic logic is_lower(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_A) && (c <= CHAR_Z);
  endfunction

endpackage

// File: rtl/vigenere_shift_cipher.sv
// Vigenere style shift cipher: one message byte in, one byte out per request.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall) carries one message byte and a
//   start-of-message flag per request. Lowercase letters are shifted by the
//   next lowercase key letter (search wraps round the key, skipping other
//   key characters); all other bytes pass through and do not use a key letter.
//   Output channel (out_valid / out_stall) returns one byte per request.
//   Configuration (cfg_valid / cfg_ready, always ready) writes decode mode,
//   key length and the two 64-bit key words; write only while idle.
// Timing:
//   An accepted byte's result reaches the output register in the next cycle.
//   Throughput is one byte per cycle while not stalled: the key search, shift
//   and key position update sit in one combinational pass before out_char_r.
// Reset:
//   rst_n clears the output valid, key position and registers (encrypt mode,
//   key length one, key all zero).
// Stall:
//   While out_stall holds a waiting result, in_stall is raised and no new
//   byte is taken; the result is taken the cycle out_stall drops.

module vigenere_shift_cipher
  import vsc_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     in_char,
  input  logic                  in_start_of_message,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     out_char,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  logic                  decode_mode_r;
  logic [LEN_W-1:0]      key_length_r;
  logic [CFG_DATA_W-1:0] key_low_r;
  logic [CFG_DATA_W-1:0] key_high_r;
  logic [IDX_W-1:0]      key_pos_r;
  logic [IDX_W-1:0]      key_pos_nxt;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic [CHAR_W-1:0]     out_char_nxt;

  logic                        in_accept;
  logic [2*CFG_DATA_W-1:0]     key_all;
  logic [LEN_W-1:0]            len_eff;
  logic [IDX_W-1:0]            pos_eff;
  logic [IDX_W-1:0]            start_idx;
  logic [KEY_MAX-1:0]          letter_mask;
  logic [KEY_MAX-1:0]          upper_mask;
  logic                        any_found;
  logic                        hi_found;
  logic [IDX_W-1:0]            any_idx;
  logic [IDX_W-1:0]            hi_idx;
  logic [IDX_W-1:0]            sel_idx;
  logic [CHAR_W-1:0]           sel_char;
  logic [LEN_W-1:0]            next_pos;
  logic [LEN_W-1:0]            plain_val;
  logic [LEN_W-1:0]            shift_val;
  logic [LEN_W:0]              mix_val;
  logic [LEN_W:0]              wrap_val;
  logic                        do_shift;

  // Handshake: take a byte whenever the output register is free or draining
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign cfg_ready = 1'b1;

  // Clamp key length to the supported key size
  assign len_eff = (key_length_r > LEN_W'(KEY_MAX)) ? LEN_W'(KEY_MAX) : key_length_r;

  // Begin the search at the current position, or at zero at message start or if out of range
  assign pos_eff   = in_start_of_message ? '0 : key_pos_r;
  assign start_idx = (LEN_W'(pos_eff) < len_eff) ? pos_eff : '0;

  assign key_all = {key_high_r, key_low_r};

  // Mark usable key letters, and those at or after the start position
  always_comb begin
    for (int i = 0; i < KEY_MAX; i++) begin
      letter_mask[i] = is_lower(key_all[CHAR_W*i +: CHAR_W]) && (LEN_W'(i) < len_eff);
      upper_mask[i]  = letter_mask[i] && (IDX_W'(i) >= start_idx);
    end
  end

  // Find the lowest marked letter in both masks
  always_comb begin
    any_found = 1'b0;
    hi_found  = 1'b0;
    any_idx   = '0;
    hi_idx    = '0;
    for (int i = KEY_MAX - 1; i >= 0; i--) begin
      if (letter_mask[i]) begin
        any_found = 1'b1;
        any_idx   = IDX_W'(i);
      end
      if (upper_mask[i]) begin
        hi_found = 1'b1;
        hi_idx   = IDX_W'(i);
      end
    end
  end

  // Wrap round the key when nothing lies at or after the start position
  assign sel_idx  = hi_found ? hi_idx : any_idx;
  assign sel_char = key_all[CHAR_W*sel_idx +: CHAR_W];
  assign do_shift = is_lower(in_char) && any_found;

  // Shift the letter modulo the alphabet length
  always_comb begin
    plain_val = LEN_W'(in_char - CHAR_A);
    shift_val = LEN_W'(sel_char - CHAR_A) + LEN_W'(1);
    if (decode_mode_r) begin
      mix_val = (LEN_W+1)'(plain_val) + (LEN_W+1)'(ALPHA_LEN) - (LEN_W+1)'(shift_val);
    end else begin
      mix_val = (LEN_W+1)'(plain_val) + (LEN_W+1)'(shift_val);
    end
    if (mix_val >= (LEN_W+1)'(ALPHA_LEN)) begin
      wrap_val = mix_val - (LEN_W+1)'(ALPHA_LEN);
    end else begin
      wrap_val = mix_val;
    end
    out_char_nxt = do_shift ? (CHAR_A + CHAR_W'(wrap_val)) : in_char;
  end

  // Advance the key position past the letter just used; otherwise keep it, cleared at message start
  always_comb begin
    next_pos = LEN_W'(sel_idx) + LEN_W'(1);
    if (do_shift) begin
      key_pos_nxt = (next_pos >= len_eff) ? '0 : next_pos[IDX_W-1:0];
    end else begin
      key_pos_nxt = pos_eff;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
      key_length_r  <= LEN_W'(1);
      key_low_r     <= '0;
      key_high_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DECODE_MODE: decode_mode_r <= cfg_data[0];
        CFG_KEY_LENGTH:  key_length_r  <= cfg_data[LEN_W-1:0];
        CFG_KEY_LOW:     key_low_r     <= cfg_data;
        CFG_KEY_HIGH:    key_high_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Key position and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      key_pos_r   <= key_pos_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_char_r <= out_char_nxt;
    end
  end

endmodule

// File: bench/vigenere_shift_cipher_tb.sv
// Self-checking bench for the shift cipher: random streams, config phases, stall pressure.
`timescale 1ns / 1ps

module vigenere_shift_cipher_tb;
  import vsc_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              som;
  } msg_byte_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // Block ports
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CHAR_W-1:0]     in_char = '0;
  logic                  in_start_of_message = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_W-1:0]     out_char;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  vigenere_shift_cipher dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char             (in_char),
    .in_start_of_message (in_start_of_message),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_char            (out_char),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Bench copy of the cipher state and registers
  logic              dec_mode_q = 1'b0;
  logic [LEN_W-1:0]  key_len_q  = 5'd1;
  logic [127:0]      key_text_q = '0;
  logic [3:0]        key_pos_q  = '0;

  msg_byte_t         pending_bytes[$];
  logic [CHAR_W-1:0] predicted_chars[$];

  int unsigned sent_cnt = 0;
  int unsigned rcv_cnt  = 0;
  int unsigned err_cnt  = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_A) && (c <= CHAR_Z);
  endfunction

  // Shift one message byte by the next usable key letter, advancing the key position
  function automatic logic [CHAR_W-1:0] shift_char(input logic [CHAR_W-1:0] c,
                                                   input logic som);
    int unsigned       len;
    int unsigned       start;
    int unsigned       idx;
    int unsigned       shift;
    int unsigned       v;
    logic [CHAR_W-1:0] kc;
    logic [CHAR_W-1:0] res;
    logic              found;
    res = c;
    found = 1'b0;
    if (som) key_pos_q = '0;
    len = 32'(key_len_q);
    if (len > KEY_MAX_DEF) len = KEY_MAX_DEF;
    if (is_letter(c) && len > 0) begin
      start = (key_pos_q < len) ? key_pos_q : 0;
      for (int k = 0; k < len; k++) begin
        idx = start + k;
        if (idx >= len) idx = idx - len;
        kc = key_text_q[8*idx +: 8];
        if (!found && is_letter(kc)) begin
          found = 1'b1;
          shift = kc - CHAR_A + 1;
          v = 32'(c - CHAR_A);
          if (dec_mode_q) v = (v + ALPHA_LEN - shift) % ALPHA_LEN;
          else v = (v + shift) % ALPHA_LEN;
          res = CHAR_W'(CHAR_A + v);
          key_pos_q = (idx + 1 >= len) ? 4'd0 : 4'(idx + 1);
        end
      end
    end
    return res;
  endfunction

  // Driver: present queued bytes, predict each one as it is taken
  always @(posedge clk) begin
    msg_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predicted_chars.push_back(shift_char(in_char, in_start_of_message));
        sent_cnt <= sent_cnt + 1;
      end
      if (pending_bytes.size() != 0 &&
          ((sent_cnt >= 700 && sent_cnt < 950) || $urandom_range(99) >= 14)) begin
        nxt = pending_bytes.pop_front();
        in_valid            <= 1'b1;
        in_char             <= nxt.ch;
        in_start_of_message <= nxt.som;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random gaps, one long hold-off, a quiet stretch
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && rcv_cnt >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 200;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !(rcv_cnt >= 700 && rcv_cnt < 950) && ($urandom_range(99) < 14);
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    logic [CHAR_W-1:0] exp_ch;
    if (rst_n && out_valid && !out_stall) begin
      rcv_cnt <= rcv_cnt + 1;
      if (predicted_chars.size() == 0) begin
        err_cnt = err_cnt + 1;
        if (err_cnt <= 10) $display("unexpected result out_char %02h", out_char);
      end else begin
        exp_ch = predicted_chars.pop_front();
        if (out_char !== exp_ch) begin
          err_cnt = err_cnt + 1;
          if (err_cnt <= 10)
            $display("mismatch out_char expected %02h actual %02h", exp_ch, out_char);
        end
      end
    end
  end

  // Write one register; caller sits at a rising edge and lowers cfg_valid afterward
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DECODE_MODE: dec_mode_q = data[0];
      CFG_KEY_LENGTH:  key_len_q  = data[LEN_W-1:0];
      CFG_KEY_LOW:     key_text_q[63:0]   = data;
      CFG_KEY_HIGH:    key_text_q[127:64] = data;
      default: ;
    endcase
  endtask

  // Hold until the block has nothing in flight
  task automatic wait_drained();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || predicted_chars.size() != 0)
      @(negedge clk);
  endtask

  // Drain, then write all four registers
  task automatic configure(input logic [63:0] dm, input logic [63:0] len,
                           input logic [63:0] lo, input logic [63:0] hi);
    wait_drained();
    @(posedge clk);
    cfg_write(CFG_DECODE_MODE, dm);
    cfg_write(CFG_KEY_LENGTH, len);
    cfg_write(CFG_KEY_LOW, lo);
    cfg_write(CFG_KEY_HIGH, hi);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [CHAR_W-1:0] ch, input logic som);
    msg_byte_t b;
    b.ch  = ch;
    b.som = som;
    pending_bytes.push_back(b);
  endtask

  // One key word: mostly letters, or no letters at all
  function automatic logic [63:0] rand_key_word(input logic no_letters);
    logic [63:0] w;
    logic [7:0]  b;
    for (int i = 0; i < 8; i++) begin
      if (no_letters) begin
        b = $urandom_range(1) ? 8'($urandom_range(8'h60)) : 8'($urandom_range(255, 8'h7b));
      end else if ($urandom_range(99) < 80) begin
        b = 8'(CHAR_A + $urandom_range(25));
      end else begin
        b = 8'($urandom_range(255));
      end
      w[8*i +: 8] = b;
    end
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_msg_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return CHAR_W'(CHAR_A + $urandom_range(25));
    if (r < 70) return $urandom_range(1) ? CHAR_A : CHAR_Z;
    return CHAR_W'($urandom_range(255));
  endfunction

  // Stimulus
  initial begin
    logic [63:0] dm;
    logic [63:0] len;
    logic        no_letters;
    int unsigned r;
    int unsigned phase_items;
    int unsigned msg_len;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset key holds no letters: everything passes through
    push_byte(CHAR_A, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(CHAR_Z, 1'b0);

    // Key "ze#ab": full-alphabet key letter, skipped non-letter, wrap round the key
    configure(64'd0, 64'd5, 64'h0000_0062_6123_657a, 64'd0);
    push_byte(CHAR_A, 1'b1);
    push_byte(CHAR_Z, 1'b0);
    push_byte(8'h60, 1'b0);
    push_byte(8'h7b, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h6d, 1'b0);
    push_byte(8'h79, 1'b0);
    push_byte(8'h71, 1'b0);
    push_byte(8'h62, 1'b1);

    // Wide register values, length above the limit, letters only in the high word
    configure(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fff3,
              64'h2323_2323_2323_2323, 64'h6867_6665_6463_6261);
    push_byte(CHAR_A, 1'b1);
    push_byte(CHAR_Z, 1'b0);
    push_byte(8'h6b, 1'b0);
    push_byte(8'h80, 1'b0);

    // Shrink the key so the position lies beyond its length
    configure(64'hffff_ffff_ffff_fffe, 64'd2, 64'h0000_0000_0000_6463, 64'd0);
    push_byte(8'h78, 1'b0);
    push_byte(8'h79, 1'b0);
    push_byte(CHAR_Z, 1'b0);

    // Zero-length key
    configure(64'd1, 64'd0, 64'h6161_6161_6161_6161, 64'h7a7a_7a7a_7a7a_7a7a);
    push_byte(CHAR_A, 1'b0);
    push_byte(8'h71, 1'b1);
    push_byte(CHAR_Z, 1'b0);

    // Random phases: new settings, then messages with occasional noise
    for (int p = 0; p < 8; p++) begin
      dm = {$urandom, $urandom};
      r = $urandom_range(99);
      if (p == 0) len = 64'd16;
      else if (p == 7) len = 64'd1;
      else if (r < 8) len = 64'd0;
      else if (r < 16) len = 64'($urandom_range(31, 17));
      else len = 64'($urandom_range(16, 1));
      if ($urandom_range(3) == 0) len[63:LEN_W] = (64-LEN_W)'({$urandom, $urandom});
      no_letters = ($urandom_range(9) == 0);
      configure(dm, len, rand_key_word(no_letters), rand_key_word(no_letters));
      phase_items = 0;
      while (phase_items < 175) begin
        msg_len = $urandom_range(40, 3);
        push_byte(rand_msg_char(), $urandom_range(9) != 0);
        for (int i = 1; i < msg_len; i++) push_byte(rand_msg_char(), $urandom_range(49) == 0);
        phase_items = phase_items + msg_len;
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (err_cnt == 0 && predicted_chars.size() == 0) begin
      $display("PASS vigenere_shift_cipher");
    end else begin
      $display("FAIL vigenere_shift_cipher");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2_000_000;
    $display("FAIL vigenere_shift_cipher");
    $finish;
  end

endmodule

// File: filelist.f
rtl/vsc_pkg.sv
rtl/vigenere_shift_cipher.sv
bench/vigenere_shift_cipher_tb.sv
